[hw/rtl/psm_pkg.sv]
// ---------------------------------------------------------------------------
// psm_pkg
// Shared types and constants of the planar shadow matrix block.
// ---------------------------------------------------------------------------
package psm_pkg;

    localparam int FRACTION_BITS_DEF = 12;
    localparam int LIGHT_W           = 24;
    localparam int POINT_W           = 16;
    localparam int ENTRY_W           = 32;
    localparam int ROWS              = 4;
    localparam int CFG_W             = 48;
    localparam int CFG_IDX_W         = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_C = 2'd2;

    // plane coefficient sequencer states
    typedef enum logic [3:0] {
        PS_IDLE,
        PS_CROSS,
        PS_SCALE,
        PS_SQSUM,
        PS_CHECK,
        PS_ROOT,
        PS_DIV_LOAD,
        PS_DIV,
        PS_DOT,
        PS_FINISH
    } plane_state_t;

    // status of the plane coefficient unit
    typedef struct packed {
        logic busy;
        logic ok;
    } plane_status_t;

endpackage

[hw/rtl/psm_plane.sv]
// ---------------------------------------------------------------------------
// psm_plane
// Computes the unit plane coefficients from three points: cross product,
// range scaling, squared length, bit-serial square root, restoring divide
// and offset dot product, one step per cycle.
// ---------------------------------------------------------------------------
module psm_plane
    import psm_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int P_W           = FRACTION_BITS + 15
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CFG_W-1:0]           point_a,
    input  logic [CFG_W-1:0]           point_b,
    input  logic [CFG_W-1:0]           point_c,
    output logic [ROWS-1:0][P_W-1:0]   coef,
    output plane_status_t              status
);

    localparam int MAG_W    = 34;
    localparam int SQ_W     = 30;
    localparam int NUM_W    = FRACTION_BITS + 31;
    localparam int DCNT_W   = $clog2(NUM_W);
    localparam int DOT_W    = P_W + 18;
    localparam int ROOT_STEPS = 32;

    plane_state_t state_reg, state_next;

    logic [1:0]                k_reg;
    logic [MAG_W-1:0]          m_reg [3];
    logic [2:0]                neg_reg;
    logic [63:0]               len2_reg;
    logic [63:0]               rv_reg;
    logic [63:0]               res_reg;
    logic [63:0]               bit_reg;
    logic [4:0]                iter_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [31:0]               rem_reg;
    logic [NUM_W-1:0]          quot_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic signed [P_W-1:0]     p_reg [ROWS];
    logic signed [DOT_W-1:0]   dot_reg;
    logic                      ok_reg;

    // point coordinates and edge vectors
    logic signed [POINT_W-1:0] ca [3];
    logic signed [POINT_W-1:0] cb [3];
    logic signed [POINT_W-1:0] cc [3];
    logic signed [POINT_W:0]   v1 [3];
    logic signed [POINT_W:0]   v2 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ca[i] = $signed(point_a[POINT_W*i +: POINT_W]);
            cb[i] = $signed(point_b[POINT_W*i +: POINT_W]);
            cc[i] = $signed(point_c[POINT_W*i +: POINT_W]);
            v1[i] = (POINT_W+1)'(ca[i]) - (POINT_W+1)'(cb[i]);
            v2[i] = (POINT_W+1)'(cb[i]) - (POINT_W+1)'(cc[i]);
        end
    end

    // one cross product component per cycle
    logic signed [POINT_W:0]   x1, x2, y1, y2;
    logic signed [2*POINT_W+1:0] pr1, pr2;
    logic signed [2*POINT_W+2:0] n_k;
    logic [2*POINT_W+2:0]      n_mag;

    always_comb
    begin
        unique case (k_reg)
            2'd0:
            begin
                x1 = v1[1]; y1 = v2[2]; x2 = v1[2]; y2 = v2[1];
            end
            2'd1:
            begin
                x1 = v1[2]; y1 = v2[0]; x2 = v1[0]; y2 = v2[2];
            end
            default:
            begin
                x1 = v1[0]; y1 = v2[1]; x2 = v1[1]; y2 = v2[0];
            end
        endcase
        pr1   = x1 * y1;
        pr2   = x2 * y2;
        n_k   = (2*POINT_W+3)'(pr1) - (2*POINT_W+3)'(pr2);
        n_mag = n_k[2*POINT_W+2] ? $unsigned(-n_k) : $unsigned(n_k);
    end

    // range check, square, root step, divide step, dot step
    logic                      big;
    logic [MAG_W-1:0]          m_k;
    logic [63:0]               sq;
    logic [63:0]               root_try;
    logic [32:0]               div_t;
    logic                      div_ge;
    logic [NUM_W-1:0]          q_final;
    logic signed [P_W-1:0]     q_signed;
    logic signed [POINT_W-1:0] c_k;
    logic signed [DOT_W-1:0]   dot_prod;
    logic [DOT_W-1:0]          dot_mag;
    logic [DOT_W-1:0]          dot_rnd;
    logic                      k_last;

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 3; i++)
            big = big | (|m_reg[i][MAG_W-1:SQ_W]);
        m_k      = m_reg[k_reg];
        sq       = 64'(m_k[SQ_W-1:0]) * 64'(m_k[SQ_W-1:0]);
        root_try = res_reg + bit_reg;
        div_t    = {rem_reg, num_reg[NUM_W-1]};
        div_ge   = div_t >= {1'b0, res_reg[31:0]};
        q_final  = {quot_reg[NUM_W-2:0], div_ge};
        q_signed = neg_reg[k_reg] ? -$signed(q_final[P_W-1:0]) : $signed(q_final[P_W-1:0]);
        c_k      = cc[k_reg];
        dot_prod = DOT_W'(p_reg[k_reg]) * DOT_W'(c_k);
        dot_mag  = dot_reg[DOT_W-1] ? $unsigned(-dot_reg) : $unsigned(dot_reg);
        dot_rnd  = (dot_mag + DOT_W'(8)) >> 4;
        k_last   = k_reg == 2'd2;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (start)
            state_next = PS_CROSS;
        else
        begin
            unique case (state_reg)
                PS_IDLE:     state_next = PS_IDLE;
                PS_CROSS:    state_next = k_last ? PS_SCALE : PS_CROSS;
                PS_SCALE:    state_next = big ? PS_SCALE : PS_SQSUM;
                PS_SQSUM:    state_next = k_last ? PS_CHECK : PS_SQSUM;
                PS_CHECK:    state_next = (len2_reg == 64'd0) ? PS_FINISH : PS_ROOT;
                PS_ROOT:     state_next = (iter_reg == 5'(ROOT_STEPS-1)) ? PS_DIV_LOAD : PS_ROOT;
                PS_DIV_LOAD: state_next = PS_DIV;
                PS_DIV:
                begin
                    if (dcnt_reg == DCNT_W'(NUM_W-1))
                        state_next = k_last ? PS_DOT : PS_DIV_LOAD;
                end
                PS_DOT:      state_next = k_last ? PS_FINISH : PS_DOT;
                PS_FINISH:   state_next = PS_IDLE;
                default:     state_next = PS_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        status.busy = state_reg != PS_IDLE;
        status.ok   = ok_reg;
        for (int r = 0; r < ROWS; r++)
            coef[r] = p_reg[r];
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            ok_reg    <= 1'b0;
            k_reg     <= 2'd0;
            for (int r = 0; r < ROWS; r++)
                p_reg[r] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
                k_reg <= 2'd0;
            else
            begin
                unique case (state_reg)
                    PS_IDLE: ;
                    PS_CROSS:
                    begin
                        m_reg[k_reg]   <= n_mag[MAG_W-1:0];
                        neg_reg[k_reg] <= n_k[2*POINT_W+2];
                        k_reg          <= k_last ? 2'd0 : k_reg + 2'd1;
                    end
                    PS_SCALE:
                    begin
                        if (big)
                            for (int i = 0; i < 3; i++)
                                m_reg[i] <= m_reg[i] >> 1;
                    end
                    PS_SQSUM:
                    begin
                        len2_reg <= ((k_reg == 2'd0) ? 64'd0 : len2_reg) + sq;
                        k_reg    <= k_last ? 2'd0 : k_reg + 2'd1;
                    end
                    PS_CHECK:
                    begin
                        rv_reg   <= len2_reg;
                        res_reg  <= 64'd0;
                        bit_reg  <= 64'd1 << 62;
                        iter_reg <= 5'd0;
                    end
                    PS_ROOT:
                    begin
                        if (rv_reg >= root_try)
                        begin
                            rv_reg  <= rv_reg - root_try;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg  <= bit_reg >> 2;
                        iter_reg <= iter_reg + 5'd1;
                    end
                    PS_DIV_LOAD:
                    begin
                        num_reg  <= NUM_W'({m_k[SQ_W-1:0], FRACTION_BITS'(0)})
                                    + NUM_W'(res_reg[31:1]);
                        rem_reg  <= 32'd0;
                        quot_reg <= '0;
                        dcnt_reg <= '0;
                    end
                    PS_DIV:
                    begin
                        rem_reg  <= div_ge ? 32'(div_t - {1'b0, res_reg[31:0]})
                                           : div_t[31:0];
                        num_reg  <= num_reg << 1;
                        quot_reg <= q_final;
                        dcnt_reg <= dcnt_reg + DCNT_W'(1);
                        if (dcnt_reg == DCNT_W'(NUM_W-1))
                        begin
                            p_reg[k_reg] <= q_signed;
                            k_reg        <= k_last ? 2'd0 : k_reg + 2'd1;
                        end
                    end
                    PS_DOT:
                    begin
                        dot_reg <= ((k_reg == 2'd0) ? DOT_W'(0) : dot_reg) + dot_prod;
                        k_reg   <= k_last ? 2'd0 : k_reg + 2'd1;
                    end
                    PS_FINISH:
                    begin
                        if (len2_reg == 64'd0)
                        begin
                            ok_reg <= 1'b0;
                            for (int r = 0; r < ROWS; r++)
                                p_reg[r] <= '0;
                        end
                        else
                        begin
                            ok_reg <= 1'b1;
                            // offset is minus the rounded dot product
                            p_reg[ROWS-1] <= dot_reg[DOT_W-1] ? $signed(dot_rnd[P_W-1:0])
                                                              : -$signed(dot_rnd[P_W-1:0]);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

[hw/rtl/planar_shadow_matrix_top.sv]
// ---------------------------------------------------------------------------
// planar_shadow_matrix_top
// Planar projected shadow matrix: one light position in, four matrix
// columns out, one beat per column.
// ---------------------------------------------------------------------------
// path: an input beat passes the s1, s2, g, c1, c2 and out registers to its first column beat
// rate: one light position per four column beats, set by the column stage which
// issues one column per cycle unless the output stalls; the output side may stall at will
// reset: plane points clear to zero, the plane reads degenerate
// a point write starts the plane unit, input held off while it runs
module planar_shadow_matrix_top
    import psm_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // light_x, light_y, light_z, light_w (24 bits each)
    input  logic [4*LIGHT_W-1:0]     s_tdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // entry_row0, entry_row1, entry_row2, entry_row3 (32 bits each)
    output logic [4*ENTRY_W-1:0]     m_tdata,
    // column_index (2 bits), degenerate (1 bit)
    output logic [2:0]               m_tuser,
    output logic                     m_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int P_W   = FRACTION_BITS + 15;
    localparam int PR_W  = P_W + LIGHT_W;
    localparam int DT_W  = P_W + LIGHT_W + 2;
    localparam int RAW_W = P_W + LIGHT_W + 3;
    localparam logic [RAW_W-1:0] HALF = RAW_W'(1) << (FRACTION_BITS - 1);
    localparam logic [RAW_W-1:0] POS_MAX = RAW_W'(32'h7fff_ffff);
    localparam logic [RAW_W-1:0] NEG_MAX = RAW_W'(33'h1_0000_0000) >> 1;

    // plane point registers
    logic [CFG_W-1:0] point_a_reg, point_b_reg, point_c_reg;
    logic             plane_start;

    assign plane_start = cfg_we && (cfg_index == REG_POINT_A || cfg_index == REG_POINT_B
                                    || cfg_index == REG_POINT_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_a_reg <= '0;
            point_b_reg <= '0;
            point_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POINT_A)
                point_a_reg <= cfg_data;
            if (cfg_index == REG_POINT_B)
                point_b_reg <= cfg_data;
            if (cfg_index == REG_POINT_C)
                point_c_reg <= cfg_data;
        end
    end

    // plane coefficient unit
    logic [ROWS-1:0][P_W-1:0] coef;
    plane_status_t            plane_status;

    psm_plane #(
        .FRACTION_BITS (FRACTION_BITS),
        .P_W           (P_W)
    ) u_plane (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (plane_start),
        .point_a (point_a_reg),
        .point_b (point_b_reg),
        .point_c (point_c_reg),
        .coef    (coef),
        .status  (plane_status)
    );

    // pipeline registers
    logic                      s1_valid_reg, s2_valid_reg, g_valid_reg;
    logic                      c1_valid_reg, c2_valid_reg, out_valid_reg;
    logic signed [LIGHT_W-1:0] s1_l_reg [ROWS];
    logic signed [LIGHT_W-1:0] s2_l_reg [ROWS];
    logic signed [LIGHT_W-1:0] g_l_reg  [ROWS];
    logic signed [PR_W-1:0]    s1_pd_reg [ROWS];
    logic signed [DT_W-1:0]    s2_dot_reg, g_dot_reg, c1_dot_reg;
    logic [1:0]                g_col_reg, c1_col_reg, c2_col_reg, out_col_reg;
    logic signed [PR_W-1:0]    c1_prod_reg [ROWS];
    logic signed [RAW_W-1:0]   c2_raw_reg [ROWS];
    logic [ENTRY_W-1:0]        out_entry_reg [ROWS];

    // stall control
    logic en, g_take, s2_free, s1_free, s_take;

    always_comb
    begin
        en       = !out_valid_reg || m_tready;
        g_take   = en && (!g_valid_reg || g_col_reg == 2'd3);
        s2_free  = !s2_valid_reg || g_take;
        s1_free  = !s1_valid_reg || s2_free;
        s_tready = s1_free && !plane_status.busy;
        s_take   = s_tvalid && s_tready;
    end

    // lane arithmetic
    logic signed [LIGHT_W-1:0] in_l [ROWS];
    logic signed [DT_W-1:0]    dot_sum;
    logic signed [LIGHT_W-1:0] l_col;
    logic [RAW_W-1:0]          raw_mag [ROWS];
    logic [RAW_W-1:0]          rnd [ROWS];
    logic [ENTRY_W-1:0]        entry [ROWS];

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
            in_l[r] = $signed(s_tdata[LIGHT_W*r +: LIGHT_W]);
        dot_sum = '0;
        for (int r = 0; r < ROWS; r++)
            dot_sum = dot_sum + DT_W'(s1_pd_reg[r]);
        l_col = g_l_reg[g_col_reg];
        // round half away from zero, then saturate
        for (int r = 0; r < ROWS; r++)
        begin
            raw_mag[r] = c2_raw_reg[r][RAW_W-1] ? $unsigned(-c2_raw_reg[r])
                                                : $unsigned(c2_raw_reg[r]);
            rnd[r] = (raw_mag[r] + HALF) >> FRACTION_BITS;
            if (c2_raw_reg[r][RAW_W-1])
                entry[r] = (rnd[r] > NEG_MAX) ? 32'h8000_0000 : 32'(-rnd[r]);
            else
                entry[r] = (rnd[r] > POS_MAX) ? 32'h7fff_ffff : rnd[r][ENTRY_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            g_valid_reg   <= 1'b0;
            g_col_reg     <= 2'd0;
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s_take;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (g_take)
            begin
                g_valid_reg <= s2_valid_reg;
                g_col_reg   <= 2'd0;
            end
            else if (en && g_valid_reg)
                g_col_reg <= g_col_reg + 2'd1;
            if (en)
            begin
                c1_valid_reg  <= g_valid_reg;
                c2_valid_reg  <= c1_valid_reg;
                out_valid_reg <= c2_valid_reg;
            end
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        // dot product lanes
        if (s1_free)
            for (int r = 0; r < ROWS; r++)
            begin
                s1_l_reg[r]  <= in_l[r];
                s1_pd_reg[r] <= $signed(coef[r]) * PR_W'(in_l[r]);
            end
        // dot product sum
        if (s2_free)
        begin
            s2_l_reg   <= s1_l_reg;
            s2_dot_reg <= dot_sum;
        end
        // column stage
        if (g_take)
        begin
            g_l_reg   <= s2_l_reg;
            g_dot_reg <= s2_dot_reg;
        end
        if (en)
        begin
            // column products
            for (int r = 0; r < ROWS; r++)
                c1_prod_reg[r] <= $signed(coef[r]) * PR_W'(l_col);
            c1_dot_reg <= g_dot_reg;
            c1_col_reg <= g_col_reg;
            // diagonal minus product
            for (int r = 0; r < ROWS; r++)
                c2_raw_reg[r] <= ((c1_col_reg == 2'(r)) ? RAW_W'(c1_dot_reg) : RAW_W'(0))
                                 - RAW_W'(c1_prod_reg[r]);
            c2_col_reg <= c1_col_reg;
            // rounded, saturated entries
            for (int r = 0; r < ROWS; r++)
                out_entry_reg[r] <= entry[r];
            out_col_reg <= c2_col_reg;
        end
    end

    // output beat
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
            m_tdata[ENTRY_W*r +: ENTRY_W] = out_entry_reg[r];
        m_tuser  = {!plane_status.ok, out_col_reg};
        m_tlast  = out_col_reg == 2'd3;
        m_tvalid = out_valid_reg;
    end

endmodule

[tb/sv/planar_shadow_matrix_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// planar_shadow_matrix_top_tb
// Drives light positions through the shadow matrix block under several plane
// settings and checks every column beat against a matrix predictor.
// ---------------------------------------------------------------------------

class column_scoreboard;
    logic [131:0] pending_columns[$];
    int           error_count;

    // note one accepted light position: four expected columns
    function void note_light(logic [131:0] cols[4]);
        for (int c = 0; c < 4; c++)
            pending_columns.push_back(cols[c]);
    endfunction

    // compare one column beat with the oldest expectation
    function void check_column(logic [127:0] data, logic [2:0] user, logic last);
        logic [131:0] exp_col;
        if (pending_columns.size() == 0)
        begin
            report_mismatch("column beat with nothing pending");
            return;
        end
        exp_col = pending_columns.pop_front();
        for (int r = 0; r < 4; r++)
            if (data[32*r +: 32] !== exp_col[32*r +: 32])
                report_mismatch($sformatf("row %0d got %h want %h", r,
                    data[32*r +: 32], exp_col[32*r +: 32]));
        if (user !== exp_col[130:128])
            report_mismatch($sformatf("tuser got %h want %h", user, exp_col[130:128]));
        if (last !== exp_col[131])
            report_mismatch($sformatf("tlast got %b want %b", last, exp_col[131]));
    endfunction

    function void report_mismatch(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endfunction
endclass

module planar_shadow_matrix_top_tb;
    import psm_pkg::*;

    localparam int FB        = FRACTION_BITS_DEF;
    localparam int CYCLE_MAX = 400000;

    logic               clk;
    logic               rst_n;
    logic [95:0]        s_tdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [127:0]       m_tdata;
    logic [2:0]         m_tuser;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    column_scoreboard   board;
    logic [47:0]        point_reg[3];
    bit                 calm_phase;
    int                 cycle_count;

    planar_shadow_matrix_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // rounding shift, half away from zero
    function automatic longint round_away(longint x, int s);
        longint m;
        m = (x < 0) ? -x : x;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // shadow matrix columns for one light position
    task automatic predict_shadow(input logic [95:0] light, output logic [131:0] cols[4]);
        longint pa[3], pb[3], pc[3], e1[3], e2[3], nrm[3], coef[4], lv[4];
        longint unsigned mg[3], len2, len, q;
        longint dotp, raw;
        bit flat;
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = longint'($signed(point_reg[0][16*k +: 16]));
            pb[k] = longint'($signed(point_reg[1][16*k +: 16]));
            pc[k] = longint'($signed(point_reg[2][16*k +: 16]));
            e1[k] = pa[k] - pb[k];
            e2[k] = pb[k] - pc[k];
        end
        nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int k = 0; k < 3; k++)
            mg[k] = (nrm[k] < 0) ? -nrm[k] : nrm[k];
        while (mg[0] >= (64'd1 << 30) || mg[1] >= (64'd1 << 30) || mg[2] >= (64'd1 << 30))
        begin
            mg[0] >>= 1;
            mg[1] >>= 1;
            mg[2] >>= 1;
        end
        len2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        flat = (len2 == 0);
        for (int k = 0; k < 4; k++)
            coef[k] = 0;
        if (!flat)
        begin
            len = int_root(len2);
            for (int k = 0; k < 3; k++)
            begin
                q = ((mg[k] << FB) + (len >> 1)) / len;
                coef[k] = (nrm[k] < 0) ? -longint'(q) : longint'(q);
            end
            coef[3] = -round_away(coef[0] * pc[0] + coef[1] * pc[1] + coef[2] * pc[2], 4);
        end
        dotp = 0;
        for (int r = 0; r < 4; r++)
        begin
            lv[r] = longint'($signed(light[24*r +: 24]));
            dotp += coef[r] * lv[r];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                raw = ((r == c) ? dotp : 0) - coef[r] * lv[c];
                cols[c][32*r +: 32] = flat ? 32'd0 : 32'(clamp32(round_away(raw, FB)));
            end
            cols[c][129:128] = 2'(c);
            cols[c][130] = flat;
            cols[c][131] = (c == 3);
        end
    endtask

    function automatic bit take_gap();
        return !calm_phase && ($urandom_range(99) < 7);
    endfunction

    // write one plane point and note it for the predictor
    task automatic write_point(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx <= REG_POINT_C)
            point_reg[idx] = value;
    endtask

    task automatic set_plane(input logic [47:0] a, input logic [47:0] b, input logic [47:0] c);
        write_point(REG_POINT_A, a);
        write_point(REG_POINT_B, b);
        write_point(REG_POINT_C, c);
    endtask

    // offer one light beat and wait for acceptance
    task automatic send_light(input logic [95:0] light);
        logic [131:0] cols[4];
        // config port goes quiet once lights flow
        cfg_we <= 1'b0;
        while (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= light;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_shadow(light, cols);
        board.note_light(cols);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (board.pending_columns.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [95:0] rand_light(int mode);
        logic [95:0] v;
        for (int k = 0; k < 4; k++)
            case (mode)
                0: v[24*k +: 24] = 24'($urandom);
                1: v[24*k +: 24] = 24'($signed(12'($urandom)));
                default: v[24*k +: 24] = ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
            endcase
        if ($urandom_range(9) == 0)
            v[72 +: 24] = '0;
        return v;
    endfunction

    function automatic logic [47:0] rand_point(int mode);
        logic [47:0] v;
        for (int k = 0; k < 3; k++)
            v[16*k +: 16] = (mode == 0) ? 16'($urandom) : 16'($signed(10'($urandom)));
        return v;
    endfunction

    // output side: random stall, check every accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_column(m_tdata, m_tuser, m_tlast);
            m_tready <= !take_gap();
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("[planar_shadow_matrix_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [47:0] pa, pb, pc;
        board = new();
        cycle_count = 0;
        calm_phase = 1'b0;
        for (int k = 0; k < 3; k++)
            point_reg[k] = '0;
        rst_n     = 1'b0;
        s_tdata   = '0;
        s_tvalid  = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_POINT_A;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset plane is degenerate
        send_light(96'h123456_FEDCBA_000001_7FFFFF);
        send_light('0);
        wait_drain();

        // simple floor plane z = 0, then extremes of the light fields
        set_plane(48'h0000_0000_0000, 48'h0000_0000_0010, 48'h0000_0010_0000);
        send_light({24'h001000, 24'h004000, 24'h002000, 24'h001000});
        send_light({24'h000000, 24'h004000, 24'h002000, 24'h001000});
        send_light({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
        send_light({24'h800000, 24'h800000, 24'h800000, 24'h800000});
        send_light({24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000});
        send_light({24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001});
        wait_drain();

        // tilted plane with offset
        set_plane(48'h0030_0010_FFE0, 48'hFFF0_0050_0020, 48'h0010_FF80_0040);
        send_light({24'h001000, 24'hFFC000, 24'h003000, 24'h00A000});
        send_light({24'h000000, 24'h123456, 24'hABCDEF, 24'h555555});
        wait_drain();

        // extreme coordinates give a large normal
        set_plane(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h7FFF_7FFF_8000);
        send_light({24'h7FFFFF, 24'h800000, 24'h001000, 24'hFFF000});
        send_light({24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000});
        wait_drain();

        // collinear and equal points, plus an unused index and high data bits
        set_plane(48'h0010_0010_0010, 48'h0020_0020_0020, 48'h0030_0030_0030);
        send_light({24'h001000, 24'h002000, 24'h003000, 24'h004000});
        wait_drain();
        set_plane(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        write_point(2'd3, 48'h1234_5678_9ABC);
        send_light({24'h7FFFFF, 24'h000000, 24'h800000, 24'h000000});
        wait_drain();

        // random phases: mostly small coordinates, some full range
        for (int ph = 0; ph < 10; ph++)
        begin
            int mode;
            mode = ($urandom_range(3) == 0) ? 0 : 1;
            pa = rand_point(mode);
            pb = rand_point(mode);
            pc = ($urandom_range(7) == 0) ? pb : rand_point(mode);
            set_plane(pa, pb, pc);
            calm_phase = (ph == 4);
            for (int i = 0; i < 20; i++)
                send_light(rand_light($urandom_range(9) == 0 ? 2 : $urandom_range(1)));
            wait_drain();
        end
        calm_phase = 1'b0;

        wait_drain();
        if (board.error_count == 0 && board.pending_columns.size() == 0)
            $display("[planar_shadow_matrix_top] OK");
        else
            $display("[planar_shadow_matrix_top] ERROR");
        $finish;
    end
endmodule

[planar_shadow_matrix_top.f]
hw/rtl/psm_pkg.sv
hw/rtl/psm_plane.sv
hw/rtl/planar_shadow_matrix_top.sv
tb/sv/planar_shadow_matrix_top_tb.sv
